// ===== hdl/view_axis_depth_sort_defines.svh =====
// Assertion macros shared by the depth sort RTL.
`ifndef VIEW_AXIS_DEPTH_SORT_DEFINES_SVH
`define VIEW_AXIS_DEPTH_SORT_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define VADS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define VADS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/vads_pkg.sv =====
// Package for the view axis depth sort: widths, register codes, types, helpers.
`timescale 1ns / 1ps
package vads_pkg;

  localparam int VADS_MAX_ITEMS = 64;
  localparam int VADS_POS_W     = 32;
  localparam int VADS_OFF_W     = VADS_POS_W + 1;
  localparam int VADS_DIR_W     = 16;
  localparam int VADS_PROD_W    = VADS_OFF_W + VADS_DIR_W;
  localparam int VADS_KEY_W     = 50;
  localparam int VADS_TAG_W     = 16;
  localparam int VADS_WORD_W    = VADS_KEY_W + VADS_TAG_W;
  localparam int VADS_CFG_IDX_W = 3;

  // Configuration register indexes
  localparam logic [VADS_CFG_IDX_W-1:0] REG_VIEWER_X    = 3'd0;
  localparam logic [VADS_CFG_IDX_W-1:0] REG_VIEWER_Y    = 3'd1;
  localparam logic [VADS_CFG_IDX_W-1:0] REG_VIEWER_ELEV = 3'd2;
  localparam logic [VADS_CFG_IDX_W-1:0] REG_DIR_X       = 3'd3;
  localparam logic [VADS_CFG_IDX_W-1:0] REG_DIR_Y       = 3'd4;
  localparam logic [VADS_CFG_IDX_W-1:0] REG_DIR_ELEV    = 3'd5;

  // Viewer position and view direction
  typedef struct packed {
    logic signed [VADS_POS_W-1:0] viewer_x;
    logic signed [VADS_POS_W-1:0] viewer_y;
    logic signed [VADS_POS_W-1:0] viewer_elev;
    logic signed [VADS_DIR_W-1:0] dir_x;
    logic signed [VADS_DIR_W-1:0] dir_y;
    logic signed [VADS_DIR_W-1:0] dir_elev;
  } vads_view_t;

  typedef enum logic [3:0] {
    ST_LOAD,   // taking points
    ST_MUL,    // products being registered
    ST_SUM,    // key summed and stored
    ST_GAP,    // growing the first gap
    ST_IRD,    // start of one insertion
    ST_VLD,    // capture element being inserted
    ST_CMP,    // compare with element one gap below
    ST_PUT,    // drop element into its slot
    ST_OLAT,   // result read back from the store
    ST_OHOLD   // result offered downstream
  } vads_state_e;

  // floor(val / 3) for 8-bit values by reciprocal multiply
  function automatic logic [7:0] vads_div3(input logic [7:0] val);
    logic [16:0] prod;
    prod = 17'(val) * 17'd171;
    return prod[16:9];
  endfunction

endpackage

// ===== hdl/vads_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module vads_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/vads_key.sv =====
// Key datapath: offsets from the viewer, three products, and their sum.
`timescale 1ns / 1ps
module vads_key (
  input  logic                                   clk_i,
  input  logic                                   start_i,
  input  vads_pkg::vads_view_t                   view_i,
  input  logic signed [vads_pkg::VADS_POS_W-1:0] point_x_i,
  input  logic signed [vads_pkg::VADS_POS_W-1:0] point_y_i,
  input  logic signed [vads_pkg::VADS_POS_W-1:0] point_height_i,
  output logic signed [vads_pkg::VADS_KEY_W-1:0] key_o
);
  import vads_pkg::*;

  logic signed [VADS_OFF_W-1:0]  off_x_q, off_y_q, off_z_q;
  logic signed [VADS_DIR_W-1:0]  dir_x_q, dir_y_q, dir_z_q;
  logic signed [VADS_PROD_W-1:0] prod_x_q, prod_y_q, prod_z_q;
  logic signed [VADS_PROD_W-1:0] prod_x_d, prod_y_d, prod_z_d;

  // Stage 1: exact 33-bit offsets, direction captured with them
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      off_x_q <= {point_x_i[VADS_POS_W-1], point_x_i}
               - {view_i.viewer_x[VADS_POS_W-1], view_i.viewer_x};
      off_y_q <= {point_y_i[VADS_POS_W-1], point_y_i}
               - {view_i.viewer_y[VADS_POS_W-1], view_i.viewer_y};
      off_z_q <= {point_height_i[VADS_POS_W-1], point_height_i}
               - {view_i.viewer_elev[VADS_POS_W-1], view_i.viewer_elev};
      dir_x_q <= view_i.dir_x;
      dir_y_q <= view_i.dir_y;
      dir_z_q <= view_i.dir_elev;
    end
  end

  // Stage 2: 16 x 33 signed products
  assign prod_x_d = dir_x_q * off_x_q;
  assign prod_y_d = dir_y_q * off_y_q;
  assign prod_z_d = dir_z_q * off_z_q;

  always_ff @(posedge clk_i) begin
    prod_x_q <= prod_x_d;
    prod_y_q <= prod_y_d;
    prod_z_q <= prod_z_d;
  end

  // Exact sum, fits the key width
  assign key_o = {prod_x_q[VADS_PROD_W-1], prod_x_q}
               + {prod_y_q[VADS_PROD_W-1], prod_y_q}
               + {prod_z_q[VADS_PROD_W-1], prod_z_q};

endmodule

// ===== hdl/view_axis_depth_sort.sv =====
// Top level of the view axis depth sort: loading, Shell sort sequencer, result output.
//
// Usage: points arrive on the input channel (in_valid_i / in_stall_o) and are
// stored with their depth key along the view direction. A point flagged with
// last_item_i closes the set: the stored points are Shell sorted (gaps
// 1, 4, 13, ...) into descending key order and sent out on the result channel
// (out_valid_o / out_stall_i), one result per stored point, farthest first.
// Non-final points give no result. Points beyond MAX_ITEMS are dropped and
// flag dropped_any_o on every result of that set.
// Configuration writes (cfg_valid_i / cfg_ready_o) must go in only while the block
// idles; the block does not enforce it. Only a stored point passes ST_MUL and
// ST_SUM. The sort keeps all points in one RAM with one read and one write port:
// each insertion passes ST_IRD, ST_VLD and ST_CMP, plus one ST_CMP or ST_PUT per
// element shifted, per gap. Results pass the registered RAM read (ST_OLAT) and the
// output register (ST_OHOLD). The input is stalled from the last point until its
// final result is taken. Reset clears the registers to zero and empties the set;
// the store is not cleared. A stalled result holds; the sequencer waits for it.
`timescale 1ns / 1ps
`include "view_axis_depth_sort_defines.svh"
module view_axis_depth_sort #(
  parameter int MAX_ITEMS = vads_pkg::VADS_MAX_ITEMS
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  // configuration
  input  logic                                       cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  logic [vads_pkg::VADS_CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [vads_pkg::VADS_POS_W-1:0]            cfg_data_i,
  // points
  input  logic                                       in_valid_i,
  output logic                                       in_stall_o,
  input  logic signed [vads_pkg::VADS_POS_W-1:0]     point_x_i,
  input  logic signed [vads_pkg::VADS_POS_W-1:0]     point_y_i,
  input  logic signed [vads_pkg::VADS_POS_W-1:0]     point_height_i,
  input  logic [vads_pkg::VADS_TAG_W-1:0]            point_tag_i,
  input  logic                                       last_item_i,
  // results
  output logic                                       out_valid_o,
  input  logic                                       out_stall_i,
  output logic [vads_pkg::VADS_TAG_W-1:0]            out_tag_o,
  output logic signed [vads_pkg::VADS_KEY_W-1:0]     sort_key_o,
  output logic                                       last_out_o,
  output logic                                       dropped_any_o
);
  import vads_pkg::*;

  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int AW = $clog2(MAX_ITEMS);
  localparam int HW = CW + 4;

  vads_state_e state_q, state_d;
  vads_view_t  cfg_q;

  logic [CW-1:0] count_q, count_d;
  logic          ovf_q, ovf_d;
  logic          last_pend_q, last_pend_d;
  logic [CW-1:0] h_q, h_d, i_q, i_d, j_q, j_d, k_q, k_d;
  logic [VADS_TAG_W-1:0] tag_q;

  logic                   in_acc, full;
  logic [VADS_KEY_W-1:0]  new_key;
  logic [CW-1:0]          h_div3, j_less_h, jn_less_h, n_less_1;
  logic [HW-1:0]          nine_h;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [VADS_WORD_W-1:0] ram_wdata, ram_rdata;
  logic [VADS_WORD_W-1:0] v_q;
  logic                   shift_up;

  logic [VADS_TAG_W-1:0]  out_tag_q;
  logic [VADS_KEY_W-1:0]  out_key_q;
  logic                   out_last_q, out_drop_q;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_VIEWER_X:    cfg_q.viewer_x    <= cfg_data_i;
        REG_VIEWER_Y:    cfg_q.viewer_y    <= cfg_data_i;
        REG_VIEWER_ELEV: cfg_q.viewer_elev <= cfg_data_i;
        REG_DIR_X:       cfg_q.dir_x       <= cfg_data_i[VADS_DIR_W-1:0];
        REG_DIR_Y:       cfg_q.dir_y       <= cfg_data_i[VADS_DIR_W-1:0];
        REG_DIR_ELEV:    cfg_q.dir_elev    <= cfg_data_i[VADS_DIR_W-1:0];
        default: ;
      endcase
    end
  end

  // Input handshake
  assign in_stall_o = (state_q != ST_LOAD);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign full       = (count_q == CW'(MAX_ITEMS));

  vads_key u_key (
    .clk_i          (clk_i),
    .start_i        (in_acc & ~full),
    .view_i         (cfg_q),
    .point_x_i      (point_x_i),
    .point_y_i      (point_y_i),
    .point_height_i (point_height_i),
    .key_o          (new_key)
  );

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      tag_q <= point_tag_i;
    end
  end

  // Point and key store
  vads_ram #(
    .WIDTH (VADS_WORD_W),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Gap arithmetic
  assign h_div3    = CW'(vads_div3(8'(h_q)));
  assign nine_h    = HW'({h_q, 3'b000}) + HW'(h_q);
  assign n_less_1  = count_q - CW'(1);
  assign j_less_h  = j_q - h_q;
  assign jn_less_h = j_less_h - h_q;

  // Element moves up while its key is strictly greater
  assign shift_up = $signed(v_q[VADS_WORD_W-1:VADS_TAG_W])
                  > $signed(ram_rdata[VADS_WORD_W-1:VADS_TAG_W]);

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      last_pend_q <= 1'b0;
      h_q         <= '0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      last_pend_q <= last_pend_d;
      h_q         <= h_d;
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
    end
  end

  // Next state, counters and store accesses
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    last_pend_d = last_pend_q;
    h_d         = h_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    ram_we      = 1'b0;
    ram_waddr   = j_q[AW-1:0];
    ram_wdata   = v_q;
    ram_raddr   = '0;

    unique case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          last_pend_d = last_item_i;
          if (full) begin
            ovf_d = 1'b1;
            if (last_item_i) begin
              h_d     = CW'(1);
              state_d = ST_GAP;
            end
          end else begin
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        state_d = ST_SUM;
      end
      ST_SUM: begin
        ram_we    = 1'b1;
        ram_waddr = count_q[AW-1:0];
        ram_wdata = {new_key, tag_q};
        count_d   = count_q + CW'(1);
        if (last_pend_q) begin
          h_d     = CW'(1);
          state_d = ST_GAP;
        end else begin
          state_d = ST_LOAD;
        end
      end
      ST_GAP: begin
        if (nine_h <= HW'(n_less_1)) begin
          h_d = {h_q[CW-2:0], 1'b0} + h_q + CW'(1);
        end else begin
          i_d     = h_q;
          state_d = ST_IRD;
        end
      end
      ST_IRD: begin
        if (i_q >= count_q) begin
          if (h_q == CW'(1)) begin
            k_d       = '0;
            ram_raddr = '0;
            state_d   = ST_OLAT;
          end else begin
            h_d = h_div3;
            i_d = h_div3;
          end
        end else begin
          ram_raddr = i_q[AW-1:0];
          j_d       = i_q;
          state_d   = ST_VLD;
        end
      end
      ST_VLD: begin
        ram_raddr = j_less_h[AW-1:0];
        state_d   = ST_CMP;
      end
      ST_CMP: begin
        ram_we = 1'b1;
        if (shift_up) begin
          ram_wdata = ram_rdata;
          j_d       = j_less_h;
          if (j_less_h >= h_q) begin
            ram_raddr = jn_less_h[AW-1:0];
          end else begin
            state_d = ST_PUT;
          end
        end else begin
          i_d     = i_q + CW'(1);
          state_d = ST_IRD;
        end
      end
      ST_PUT: begin
        ram_we  = 1'b1;
        i_d     = i_q + CW'(1);
        state_d = ST_IRD;
      end
      ST_OLAT: begin
        state_d = ST_OHOLD;
      end
      ST_OHOLD: begin
        if (!out_stall_i) begin
          if (k_q == n_less_1) begin
            count_d     = '0;
            ovf_d       = 1'b0;
            last_pend_d = 1'b0;
            state_d     = ST_LOAD;
          end else begin
            k_d       = k_q + CW'(1);
            ram_raddr = k_d[AW-1:0];
            state_d   = ST_OLAT;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // Element under insertion
  always_ff @(posedge clk_i) begin
    if (state_q == ST_VLD) begin
      v_q <= ram_rdata;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (state_q == ST_OLAT) begin
      out_tag_q  <= ram_rdata[VADS_TAG_W-1:0];
      out_key_q  <= ram_rdata[VADS_WORD_W-1:VADS_TAG_W];
      out_last_q <= (k_q == n_less_1);
      out_drop_q <= ovf_q;
    end
  end

  assign out_valid_o   = (state_q == ST_OHOLD);
  assign out_tag_o     = out_tag_q;
  assign sort_key_o    = out_key_q;
  assign last_out_o    = out_last_q;
  assign dropped_any_o = out_drop_q;

  // Checks
  `VADS_ASSERT_NOW(a_count_range, 1'b1, count_q <= CW'(MAX_ITEMS),
    "item count beyond capacity")
  `VADS_ASSERT_NOW(a_no_load_while_out, out_valid_o, in_stall_o,
    "input open while results pending")
  `VADS_ASSERT_NXT(a_set_closed, out_valid_o && !out_stall_i && last_out_o,
    count_q == '0 && !ovf_q && !in_stall_o, "set not cleared after final result")
  `VADS_ASSERT_NOW(a_sort_write_range, ram_we && (state_q == ST_CMP || state_q == ST_PUT),
    j_q < count_q && j_q <= i_q, "sort write outside stored items")

endmodule

// ===== sim/depth_order_checker.sv =====
// Checker for the depth sort: tracks the view registers, predicts each sorted run, compares results.
`timescale 1ns / 1ps
module depth_order_checker #(
  parameter int MAX_ITEMS = vads_pkg::VADS_MAX_ITEMS
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_valid_i,
  input  logic                                   cfg_ready_i,
  input  logic [vads_pkg::VADS_CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [vads_pkg::VADS_POS_W-1:0]        cfg_data_i,
  input  logic                                   in_valid_i,
  input  logic                                   in_stall_i,
  input  logic signed [vads_pkg::VADS_POS_W-1:0] point_x_i,
  input  logic signed [vads_pkg::VADS_POS_W-1:0] point_y_i,
  input  logic signed [vads_pkg::VADS_POS_W-1:0] point_height_i,
  input  logic [vads_pkg::VADS_TAG_W-1:0]        point_tag_i,
  input  logic                                   last_item_i,
  input  logic                                   out_valid_i,
  input  logic                                   out_stall_i,
  input  logic [vads_pkg::VADS_TAG_W-1:0]        out_tag_i,
  input  logic signed [vads_pkg::VADS_KEY_W-1:0] sort_key_i,
  input  logic                                   last_out_i,
  input  logic                                   dropped_any_i,
  output int                                     fail_count_o,
  output int                                     pending_o,
  output int                                     checked_o
);
  import vads_pkg::*;

  typedef struct packed {
    logic [VADS_TAG_W-1:0]        tag;
    logic signed [VADS_KEY_W-1:0] key;
    logic                         last;
    logic                         dropped;
  } run_entry_t;

  // predictor state
  vads_view_t                   view_regs = '0;
  logic signed [VADS_KEY_W-1:0] key_mem [MAX_ITEMS];
  logic [VADS_TAG_W-1:0]        tag_mem [MAX_ITEMS];
  int                           held_cnt  = 0;
  bit                           lost_any  = 1'b0;
  run_entry_t                   sorted_run_q [$];

  int                           fail_cnt    = 0;
  int                           checked_cnt = 0;
  run_entry_t                   want;
  int                           k;

  assign fail_count_o = fail_cnt;
  assign checked_o    = checked_cnt;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    fail_cnt++;
  endtask

  // depth along the view axis; exact in 64 bits, always fits the key width
  function automatic logic signed [VADS_KEY_W-1:0] view_depth(
    input logic signed [VADS_POS_W-1:0] px,
    input logic signed [VADS_POS_W-1:0] py,
    input logic signed [VADS_POS_W-1:0] ph
  );
    longint sum;
    sum = longint'($signed(view_regs.dir_x)) *
            (longint'(px) - longint'($signed(view_regs.viewer_x)))
        + longint'($signed(view_regs.dir_y)) *
            (longint'(py) - longint'($signed(view_regs.viewer_y)))
        + longint'($signed(view_regs.dir_elev)) *
            (longint'(ph) - longint'($signed(view_regs.viewer_elev)));
    return sum[VADS_KEY_W-1:0];
  endfunction

  // Shell sort, gaps 1, 4, 13, ..., descending; moves only on a strictly greater key
  function automatic void order_far_first(input int n);
    int                           gap;
    int                           i;
    int                           j;
    logic signed [VADS_KEY_W-1:0] vk;
    logic [VADS_TAG_W-1:0]        vt;
    gap = 1;
    while (gap <= (n - 1) / 9) gap = 3 * gap + 1;
    while (gap > 0) begin
      for (i = gap; i < n; i++) begin
        vk = key_mem[i];
        vt = tag_mem[i];
        j  = i;
        while (j >= gap && vk > key_mem[j - gap]) begin
          key_mem[j] = key_mem[j - gap];
          tag_mem[j] = tag_mem[j - gap];
          j -= gap;
        end
        key_mem[j] = vk;
        tag_mem[j] = vt;
      end
      gap = gap / 3;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      view_regs = '0;
      held_cnt  = 0;
      lost_any  = 1'b0;
      sorted_run_q.delete();
      pending_o <= 0;
    end else begin
      // compare an accepted result with the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (sorted_run_q.size() == 0) begin
          report_mismatch($sformatf("result tag %h key %0d with none expected",
                                    out_tag_i, sort_key_i));
        end else begin
          want = sorted_run_q.pop_front();
          if (out_tag_i !== want.tag)
            report_mismatch($sformatf("result %0d tag got %h want %h",
                                      checked_cnt, out_tag_i, want.tag));
          if (sort_key_i !== want.key)
            report_mismatch($sformatf("result %0d key got %0d want %0d",
                                      checked_cnt, sort_key_i, $signed(want.key)));
          if (last_out_i !== want.last)
            report_mismatch($sformatf("result %0d last got %b want %b",
                                      checked_cnt, last_out_i, want.last));
          if (dropped_any_i !== want.dropped)
            report_mismatch($sformatf("result %0d dropped got %b want %b",
                                      checked_cnt, dropped_any_i, want.dropped));
          checked_cnt++;
        end
      end

      // accepted point: store its key, or note the drop; last point emits the run
      if (in_valid_i && !in_stall_i) begin
        if (held_cnt < MAX_ITEMS) begin
          key_mem[held_cnt] = view_depth(point_x_i, point_y_i, point_height_i);
          tag_mem[held_cnt] = point_tag_i;
          held_cnt++;
        end else begin
          lost_any = 1'b1;
        end
        if (last_item_i) begin
          order_far_first(held_cnt);
          for (k = 0; k < held_cnt; k++) begin
            want.tag     = tag_mem[k];
            want.key     = key_mem[k];
            want.last    = (k == held_cnt - 1);
            want.dropped = lost_any;
            sorted_run_q.push_back(want);
          end
          held_cnt = 0;
          lost_any = 1'b0;
        end
      end

      // register write; unknown indexes are ignored
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_VIEWER_X:    view_regs.viewer_x    = cfg_data_i;
          REG_VIEWER_Y:    view_regs.viewer_y    = cfg_data_i;
          REG_VIEWER_ELEV: view_regs.viewer_elev = cfg_data_i;
          REG_DIR_X:       view_regs.dir_x       = cfg_data_i[VADS_DIR_W-1:0];
          REG_DIR_Y:       view_regs.dir_y       = cfg_data_i[VADS_DIR_W-1:0];
          REG_DIR_ELEV:    view_regs.dir_elev    = cfg_data_i[VADS_DIR_W-1:0];
          default: ;
        endcase
      end

      pending_o <= sorted_run_q.size();
    end
  end

endmodule

// ===== sim/tb_view_axis_depth_sort.sv =====
// Testbench top for the depth sort: clock, reset, point and register stimulus, verdict.
`timescale 1ns / 1ps
module tb_view_axis_depth_sort;
  import vads_pkg::*;

  localparam int MAX_ITEMS   = VADS_MAX_ITEMS;
  localparam int IDLE_LIMIT  = 20000;
  localparam int HOLD_CYCLES = 300;
  localparam int GAP_MAX     = 19;
  localparam int PHASE_ITEMS = 31;

  // indexes past the register file, writes there must be ignored
  localparam logic [VADS_CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [VADS_CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  logic                         clk_i;
  logic                         rst_ni         = 1'b0;
  logic                         cfg_valid_i    = 1'b0;
  logic                         cfg_ready_o;
  logic [VADS_CFG_IDX_W-1:0]    cfg_index_i    = '0;
  logic [VADS_POS_W-1:0]        cfg_data_i     = '0;
  logic                         in_valid_i     = 1'b0;
  logic                         in_stall_o;
  logic signed [VADS_POS_W-1:0] point_x_i      = '0;
  logic signed [VADS_POS_W-1:0] point_y_i      = '0;
  logic signed [VADS_POS_W-1:0] point_height_i = '0;
  logic [VADS_TAG_W-1:0]        point_tag_i    = '0;
  logic                         last_item_i    = 1'b0;
  logic                         out_valid_o;
  logic                         out_stall_i    = 1'b0;
  logic [VADS_TAG_W-1:0]        out_tag_o;
  logic signed [VADS_KEY_W-1:0] sort_key_o;
  logic                         last_out_o;
  logic                         dropped_any_o;

  int fail_count;
  int results_pending;
  int results_checked;
  int hold_req    = 0;
  bit no_wait     = 1'b0;
  int point_cnt   = 0;
  int set_cnt     = 0;
  int full_cnt    = 0;
  int setting_cnt = 0;
  int idle_run    = 0;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  view_axis_depth_sort #(.MAX_ITEMS(MAX_ITEMS)) dut (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o,
    .point_x_i, .point_y_i, .point_height_i, .point_tag_i, .last_item_i,
    .out_valid_o, .out_stall_i,
    .out_tag_o, .sort_key_o, .last_out_o, .dropped_any_o
  );

  depth_order_checker #(.MAX_ITEMS(MAX_ITEMS)) u_checker (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o),
    .point_x_i, .point_y_i, .point_height_i, .point_tag_i, .last_item_i,
    .out_valid_i(out_valid_o), .out_stall_i,
    .out_tag_i(out_tag_o), .sort_key_i(sort_key_o),
    .last_out_i(last_out_o), .dropped_any_i(dropped_any_o),
    .fail_count_o(fail_count), .pending_o(results_pending), .checked_o(results_checked)
  );

  // one register write request; valid stays up for a following write
  task automatic write_reg(input logic [VADS_CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // full view setting, optionally followed by writes to unused indexes
  task automatic program_view(input logic [31:0] vx, vy, ve, dx, dy, de, input bit spare);
    write_reg(REG_VIEWER_X, vx);
    write_reg(REG_VIEWER_Y, vy);
    write_reg(REG_VIEWER_ELEV, ve);
    write_reg(REG_DIR_X, dx);
    write_reg(REG_DIR_Y, dy);
    write_reg(REG_DIR_ELEV, de);
    if (spare) begin
      write_reg(REG_SPARE_6, $urandom);
      write_reg(REG_SPARE_7, $urandom);
    end
    cfg_valid_i <= 1'b0;
    setting_cnt++;
  endtask

  // one point request after a random gap
  task automatic send_point(input logic [31:0] x, y, h, input logic [15:0] tag,
                            input logic last);
    int gap;
    gap = no_wait ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    point_x_i      <= x;
    point_y_i      <= y;
    point_height_i <= h;
    point_tag_i    <= tag;
    last_item_i    <= last;
    do @(posedge clk_i); while (in_stall_o);
    point_cnt++;
  endtask

  // mostly random coordinates, with the extremes now and then
  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 15))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // random set of n points; repeated positions give equal keys
  task automatic send_set(input int n);
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] h;
    x       = pick_coord();
    y       = pick_coord();
    h       = pick_coord();
    no_wait = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(0, 3) != 0) begin
        x = pick_coord();
        y = pick_coord();
        h = pick_coord();
      end
      send_point(x, y, h, 16'($urandom), i == n - 1);
    end
    set_cnt++;
    if (n > MAX_ITEMS) full_cnt++;
  endtask

  // let every predicted result drain, then let the design settle
  task automatic await_idle();
    in_valid_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (results_pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // result side: random stall before each result, plus one long hold
  initial begin
    int n;
    forever begin
      if (hold_req > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold_req) @(posedge clk_i);
        hold_req = 0;
      end
      n = no_wait ? 0 : $urandom_range(0, GAP_MAX);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // watchdog on cycles with no request moving anywhere
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((cfg_valid_i && cfg_ready_o) || (in_valid_i && !in_stall_o) ||
          (out_valid_o && !out_stall_i)) begin
        idle_run <= 0;
      end else if (idle_run >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end else begin
        idle_run <= idle_run + 1;
      end
    end
  end

  initial begin
    int budget;
    int n;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // registers at reset: every key is zero, order of equal keys
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 16'hFFFF, 1'b1);
    set_cnt++;
    for (int i = 0; i < 5; i++) send_point($urandom, $urandom, $urandom, 16'(i), i == 4);
    set_cnt++;

    // viewer at the minimum, direction at both extremes
    await_idle();
    program_view(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h0000_7FFF, 32'h0000_8000, 32'h0000_7FFF, 1'b1);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0000, 1'b0);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 1'b0);
    send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'h0001, 1'b0);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0002, 1'b0);
    send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0003, 1'b0);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h0004, 1'b0);
    send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'h0005, 1'b0);
    send_point(32'h1234_5678, 32'h89AB_CDEF, 32'h7FFF_FFFF, 16'h0006, 1'b1);
    set_cnt++;

    // viewer at the maximum, direction all most negative
    await_idle();
    program_view(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 1'b0);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'hAAAA, 1'b0);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h5555, 1'b0);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 16'h0007, 1'b0);
    send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'h0008, 1'b0);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h0009, 1'b0);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 16'h000A, 1'b1);
    set_cnt++;

    // random phases, each under a fresh view setting
    for (int p = 0; p < 6; p++) begin
      await_idle();
      case (p % 3)
        0: program_view($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 1'b0);
        1: program_view($urandom, $urandom, $urandom, $urandom & 32'hFFFF_0000,
                        $urandom & 32'hFFFF_0000, $urandom & 32'hFFFF_0000, 1'b1);
        default: program_view($urandom_range(0, 4095), $urandom_range(0, 4095),
                              $urandom_range(0, 4095), $urandom, $urandom, $urandom, 1'b0);
      endcase
      // store full: the closing point itself is dropped
      if (p == 0) send_set(MAX_ITEMS + 1);
      if (p == 4) send_set(MAX_ITEMS + 3);
      // results held off long while the next points wait at the stalled input
      if (p == 2) hold_req = HOLD_CYCLES;
      budget = 0;
      while (budget < PHASE_ITEMS) begin
        n = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 12);
        send_set(n);
        budget += n;
      end
    end

    await_idle();
    repeat (20) @(posedge clk_i);
    $display("covered %0d points in %0d sets (%0d over capacity) under %0d view settings",
             point_cnt, set_cnt, full_cnt, setting_cnt);
    $display("%0d sorted results compared, %0d mismatches", results_checked, fail_count);
    if (fail_count == 0 && results_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
